// File: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths and function codes for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

   // width of the coordinate fields on the ports
   localparam int FIELD_BITS  = 12;
   // coordinate bits used by the stepper, at most FIELD_BITS
   localparam int COORD_BITS  = 12;
   // signed error term, holds -(span-1)..span
   localparam int ERR_BITS    = COORD_BITS + 2;
   localparam int COLOUR_BITS = 32;

   typedef logic [COORD_BITS-1:0] coord_type;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

endpackage

// File: sv/line_pixel_stepper_unit.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper_unit
// 4-connected line rasterizer: a start item loads two endpoints, each step
// item gives the next pixel with the fill colour and a last flag.
// ----------------------------------------------------------------------------
// a pixel is shown in the cycle after its step item is accepted
// throughput: one item per cycle while req_stall is low; the walk is one add and compare on the
// registered line state, feeding a single result register
// req_stall is high only while the result register holds an unaccepted item
// reset (synchronous): line idle, result register empty, fill colour zero
module line_pixel_stepper_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [lps_pkg::FIELD_BITS-1:0]      req_start_x,
   input  logic [lps_pkg::FIELD_BITS-1:0]      req_start_y,
   input  logic [lps_pkg::FIELD_BITS-1:0]      req_end_x,
   input  logic [lps_pkg::FIELD_BITS-1:0]      req_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lps_pkg::FIELD_BITS-1:0]      rsp_pixel_x,
   output logic [lps_pkg::FIELD_BITS-1:0]      rsp_pixel_y,
   output logic [lps_pkg::COLOUR_BITS-1:0]     rsp_pixel_colour,
   output logic                                rsp_last_pixel,
   input  logic                                csr_wr_en,
   input  logic [lps_pkg::COLOUR_BITS-1:0]     csr_wr_data
);

   localparam int CB = lps_pkg::COORD_BITS;
   localparam int EB = lps_pkg::ERR_BITS;

   // line state
   lps_pkg::coord_type major_pos_ff,  major_pos_in;
   lps_pkg::coord_type minor_pos_ff,  minor_pos_in;
   lps_pkg::coord_type major_stop_ff, major_stop_in;
   lps_pkg::coord_type minor_stop_ff, minor_stop_in;
   lps_pkg::coord_type major_span_ff, major_span_in;
   lps_pkg::coord_type minor_span_ff, minor_span_in;
   logic signed [EB-1:0] error_term_ff, error_term_in;
   logic minor_down_ff,   minor_down_in;
   logic y_is_major_ff,   y_is_major_in;
   logic axis_aligned_ff, axis_aligned_in;
   logic line_active_ff,  line_active_in;

   logic [lps_pkg::COLOUR_BITS-1:0] fill_colour_ff;

   // result register
   logic                              out_valid_ff, out_valid_in;
   logic [lps_pkg::FIELD_BITS-1:0]    out_x_ff, out_x_in;
   logic [lps_pkg::FIELD_BITS-1:0]    out_y_ff, out_y_in;
   logic [lps_pkg::COLOUR_BITS-1:0]   out_colour_ff, out_colour_in;
   logic                              out_last_ff, out_last_in;

   logic accept;
   logic out_free;

   // start decode
   lps_pkg::coord_type sx, sy, ex, ey;
   lps_pkg::coord_type adx, ady;
   lps_pkg::coord_type u0, v0, u1, v1;
   logic               y_major_ld;
   logic               swap_ld;

   // step
   logic               take_major;
   lps_pkg::coord_type step_major, step_minor;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   always_comb begin
      sx = req_start_x[CB-1:0];
      sy = req_start_y[CB-1:0];
      ex = req_end_x[CB-1:0];
      ey = req_end_y[CB-1:0];
      adx = (sx > ex) ? sx - ex : ex - sx;
      ady = (sy > ey) ? sy - ey : ey - sy;
      // vertical lines and ties pick y; horizontal lines pick x
      y_major_ld = !(adx > ady);
      if (y_major_ld) begin
         u0 = sy; v0 = sx; u1 = ey; v1 = ex;
      end else begin
         u0 = sx; v0 = sy; u1 = ex; v1 = ey;
      end
      // walk from the smaller major end
      swap_ld = (u1 < u0);
      if (swap_ld) begin
         u0 = u1; u1 = y_major_ld ? sy : sx;
         v0 = v1; v1 = y_major_ld ? sx : sy;
      end
   end

   always_comb begin
      take_major = axis_aligned_ff || (!error_term_ff[EB-1] && (error_term_ff != '0));
      step_major = major_pos_ff;
      step_minor = minor_pos_ff;
      if (take_major) begin
         step_major = major_pos_ff + 1'b1;
      end else if (minor_down_ff) begin
         step_minor = minor_pos_ff - 1'b1;
      end else begin
         step_minor = minor_pos_ff + 1'b1;
      end
   end

   always_comb begin
      major_pos_in    = major_pos_ff;
      minor_pos_in    = minor_pos_ff;
      major_stop_in   = major_stop_ff;
      minor_stop_in   = minor_stop_ff;
      major_span_in   = major_span_ff;
      minor_span_in   = minor_span_ff;
      error_term_in   = error_term_ff;
      minor_down_in   = minor_down_ff;
      y_is_major_in   = y_is_major_ff;
      axis_aligned_in = axis_aligned_ff;
      line_active_in  = line_active_ff;

      out_valid_in  = out_valid_ff && rsp_stall;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_colour_in = out_colour_ff;
      out_last_in   = out_last_ff;

      if (accept) begin
         if (req_func == lps_pkg::FUNC_START) begin
            major_pos_in    = u0;
            minor_pos_in    = v0;
            major_stop_in   = u1;
            minor_stop_in   = v1;
            major_span_in   = u1 - u0;
            minor_span_in   = (v1 > v0) ? v1 - v0 : v0 - v1;
            error_term_in   = '0;
            minor_down_in   = (v1 < v0);
            y_is_major_in   = y_major_ld;
            axis_aligned_in = (sx == ex) || (sy == ey);
            // identical endpoints give an empty line
            line_active_in  = (u0 != u1);
         end else if (line_active_ff) begin
            major_pos_in = step_major;
            minor_pos_in = step_minor;
            if (take_major) begin
               if (!axis_aligned_ff) begin
                  error_term_in = error_term_ff - $signed({2'b00, minor_span_ff});
               end
            end else begin
               error_term_in = error_term_ff + $signed({2'b00, major_span_ff});
            end
            out_last_in    = (step_major == major_stop_ff) && (step_minor == minor_stop_ff);
            line_active_in = !out_last_in;
            out_valid_in   = 1'b1;
            out_x_in = lps_pkg::FIELD_BITS'(y_is_major_ff ? minor_pos_ff : major_pos_ff);
            out_y_in = lps_pkg::FIELD_BITS'(y_is_major_ff ? major_pos_ff : minor_pos_ff);
            out_colour_in  = fill_colour_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_pos_ff    <= '0;
         minor_pos_ff    <= '0;
         major_stop_ff   <= '0;
         minor_stop_ff   <= '0;
         major_span_ff   <= '0;
         minor_span_ff   <= '0;
         error_term_ff   <= '0;
         minor_down_ff   <= 1'b0;
         y_is_major_ff   <= 1'b0;
         axis_aligned_ff <= 1'b0;
         line_active_ff  <= 1'b0;
         fill_colour_ff  <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         major_pos_ff    <= major_pos_in;
         minor_pos_ff    <= minor_pos_in;
         major_stop_ff   <= major_stop_in;
         minor_stop_ff   <= minor_stop_in;
         major_span_ff   <= major_span_in;
         minor_span_ff   <= minor_span_in;
         error_term_ff   <= error_term_in;
         minor_down_ff   <= minor_down_in;
         y_is_major_ff   <= y_is_major_in;
         axis_aligned_ff <= axis_aligned_in;
         line_active_ff  <= line_active_in;
         out_valid_ff    <= out_valid_in;
         if (csr_wr_en) begin
            fill_colour_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_colour_ff <= out_colour_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_colour = out_colour_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule

// File: sv/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks for the line pixel stepper, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_func,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lps_pkg::FIELD_BITS-1:0]      rsp_pixel_x,
   input logic [lps_pkg::FIELD_BITS-1:0]      rsp_pixel_y,
   input logic [lps_pkg::COLOUR_BITS-1:0]     rsp_pixel_colour,
   input logic                                rsp_last_pixel
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_pixel_colour) && $stable(rsp_last_pixel))
      else $error("stalled result changed");

   // a start item never produces a pixel
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == lps_pkg::FUNC_START) && !rsp_valid
      |=> !rsp_valid)
      else $error("start item produced a result");

   // the input side only waits on a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind line_pixel_stepper_unit lps_checker u_lps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_x      (rsp_pixel_x),
   .rsp_pixel_y      (rsp_pixel_y),
   .rsp_pixel_colour (rsp_pixel_colour),
   .rsp_last_pixel   (rsp_last_pixel)
);
